@@ rtl/bagsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bagsc_pkg
// Shared types and constants of the bit array get / set / copy block.
// ----------------------------------------------------------------------------
package bagsc_pkg;

    // store geometry
    localparam int WORD_BITS  = 32;
    localparam int BIT_SEL_W  = 5;      // bit position inside one word

    // field widths
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 11;
    localparam int CNT_W      = 12;

    // largest number of words that an 11-bit bit address can reach
    localparam int MAX_WORDS  = 2 ** (ADDR_W - BIT_SEL_W);

    // stream widths
    localparam int S_TDATA_W  = 40;     // 35 bits of fields, padded to bytes
    localparam int M_TDATA_W  = 8;      // 2 bits of fields, padded to a byte

    // operation codes
    localparam logic [OP_W-1:0] OP_GET  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_COPY = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [BIT_SEL_W-1:0] t_bit_sel;

    // replace one bit of a word
    function automatic t_word put_bit(input t_word w, input t_bit_sel pos, input logic b);
        t_word m;
        m = t_word'(1) << pos;
        return b ? (w | m) : (w & ~m);
    endfunction

endpackage

@@ rtl/bagsc_ram.sv @@
// ----------------------------------------------------------------------------
// bagsc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bagsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/bit_array_get_set_copy.sv @@
// ----------------------------------------------------------------------------
// bit_array_get_set_copy
// Bit-addressable store of 32-bit words with single-bit get and set and a
// bit-serial copy of a run of bits in ascending order.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready| tuser: operation
//            |           |                              | tdata: bit_address,
//            |           |                              |   bit_value, dest_address,
//            |           |                              |   bit_count
//  m_axis    | out       | m_axis_tvalid / m_axis_tready| tdata: read_bit, range_error
//
//  order: a get or set reads the word, then returns the result and writes it back;
//  a copy of n > 0 bits goes bit by bit: each bit is a read of the source and
//  destination words followed by a write of the destination word, the RAM's
//  registered read setting the pace; errors, empty copies and unknown
//  operations finish in the cycle they are accepted
//  reset: synchronous, active low; every word reads as zero afterwards, tracked
//  by one valid flag per word, so no clearing pass is needed
//  stalls: one transaction is worked at a time; a finished result waits in a
//  holding register while the output register is full, and the next
//  transaction is accepted as soon as the current one has left the datapath
// ----------------------------------------------------------------------------
module bit_array_get_set_copy
    import bagsc_pkg::*;
#(
    parameter int STORE_WORDS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [10:0] bit_address, [11] bit_value, [22:12] dest_address,
    // [34:23] bit_count, [39:35] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]      s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] read_bit, [1] range_error, [7:2] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // only words an 11-bit address reaches are ever stored
    localparam int MEM_WORDS = (STORE_WORDS < MAX_WORDS) ? STORE_WORDS : MAX_WORDS;
    localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int LIM_W     = $clog2(STORE_WORDS * WORD_BITS + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int CMP_W     = (LIM_W > SUM_W) ? LIM_W : SUM_W;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(STORE_WORDS * WORD_BITS);

    // controller states
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transaction
    localparam logic [2:0] ST_ACC  = 3'd1;  // get / set word is back from the RAM
    localparam logic [2:0] ST_CRD  = 3'd2;  // copy: read source and destination
    localparam logic [2:0] ST_CWR  = 3'd3;  // copy: move one bit
    localparam logic [2:0] ST_DONE = 3'd4;  // result held until output is free

    // input field unpacking
    logic [ADDR_W-1:0] s_src;
    logic              s_val;
    logic [ADDR_W-1:0] s_dst;
    logic [CNT_W-1:0]  s_cnt;
    logic [OP_W-1:0]   s_op;

    assign s_src = s_axis_tdata[ADDR_W-1:0];
    assign s_val = s_axis_tdata[ADDR_W];
    assign s_dst = s_axis_tdata[2*ADDR_W:ADDR_W+1];
    assign s_cnt = s_axis_tdata[2*ADDR_W+CNT_W:2*ADDR_W+1];
    assign s_op  = s_axis_tuser;

    // registers
    logic [2:0]           r_state,  n_state;
    logic [OP_W-1:0]      r_op,     n_op;
    logic [ADDR_W-1:0]    r_src,    n_src;
    logic [ADDR_W-1:0]    r_dst,    n_dst;
    logic [CNT_W-1:0]     r_cnt,    n_cnt;
    logic                 r_val,    n_val;
    logic                 r_res_bit, n_res_bit;
    logic                 r_res_err, n_res_err;
    logic                 r_m_valid, n_m_valid;
    logic                 r_m_bit,   n_m_bit;
    logic                 r_m_err,   n_m_err;
    logic [MEM_WORDS-1:0] r_vld,    n_vld;

    // range checks on the incoming transaction
    logic [CMP_W-1:0] src_end;
    logic [CMP_W-1:0] dst_end;
    logic             src_bad;
    logic             dst_bad;
    logic             copy_bad;

    assign src_end  = CMP_W'(s_src) + CMP_W'(s_cnt);
    assign dst_end  = CMP_W'(s_dst) + CMP_W'(s_cnt);
    assign src_bad  = CMP_W'(s_src) >= LIMIT;
    assign dst_bad  = CMP_W'(s_dst) >= LIMIT;
    assign copy_bad = src_bad | dst_bad | (src_end > LIMIT) | (dst_end > LIMIT);

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_word         ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    t_word         ram_rdata_a;
    t_word         ram_rdata_b;

    logic [AW-1:0] src_idx;
    logic [AW-1:0] dst_idx;
    t_word         word_a;
    t_word         word_b;
    logic          bit_a;
    logic          idle;
    logic          acc;
    logic          out_free;

    assign idle     = (r_state == ST_IDLE);
    assign acc      = s_axis_tvalid & idle;
    assign out_free = ~r_m_valid | m_axis_tready;

    assign src_idx = r_src[BIT_SEL_W +: AW];
    assign dst_idx = r_dst[BIT_SEL_W +: AW];

    // in idle the read goes straight from the incoming addresses
    assign ram_raddr_a = idle ? s_src[BIT_SEL_W +: AW] : src_idx;
    assign ram_raddr_b = idle ? s_dst[BIT_SEL_W +: AW] : dst_idx;

    // a word never written since reset reads as zero
    assign word_a = r_vld[src_idx] ? ram_rdata_a : '0;
    assign word_b = r_vld[dst_idx] ? ram_rdata_b : '0;
    assign bit_a  = word_a[r_src[BIT_SEL_W-1:0]];

    bagsc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // finish of the current transaction
    logic f_fin;
    logic f_bit;
    logic f_err;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_src     = r_src;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_val     = r_val;
        n_res_bit = r_res_bit;
        n_res_err = r_res_err;
        n_vld     = r_vld;
        n_m_valid = r_m_valid & ~m_axis_tready;
        n_m_bit   = r_m_bit;
        n_m_err   = r_m_err;
        ram_we    = 1'b0;
        ram_waddr = src_idx;
        ram_wdata = put_bit(word_a, r_src[BIT_SEL_W-1:0], r_val);
        f_fin     = 1'b0;
        f_bit     = 1'b0;
        f_err     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_op  = s_op;
                    n_src = s_src;
                    n_dst = s_dst;
                    n_cnt = s_cnt;
                    n_val = s_val;
                    unique case (s_op)
                        OP_GET, OP_SET: begin
                            if (src_bad) begin
                                f_fin = 1'b1;
                                f_err = 1'b1;
                            end else begin
                                n_state = ST_ACC;
                            end
                        end
                        OP_COPY: begin
                            if (copy_bad || s_cnt == '0) begin
                                f_fin = 1'b1;
                                f_err = copy_bad;
                            end else begin
                                n_state = ST_CWR;
                            end
                        end
                        default: begin
                            // unknown operation: empty result
                            f_fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_ACC: begin
                f_fin = 1'b1;
                if (r_op == OP_GET) begin
                    f_bit = bit_a;
                end else begin
                    ram_we         = 1'b1;
                    n_vld[src_idx] = 1'b1;
                end
            end
            ST_CWR: begin
                // move one bit, source into destination word
                ram_we         = 1'b1;
                ram_waddr      = dst_idx;
                ram_wdata      = put_bit(word_b, r_dst[BIT_SEL_W-1:0], bit_a);
                n_vld[dst_idx] = 1'b1;
                n_src          = r_src + ADDR_W'(1);
                n_dst          = r_dst + ADDR_W'(1);
                n_cnt          = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    f_fin = 1'b1;
                end else begin
                    n_state = ST_CRD;
                end
            end
            ST_CRD: begin
                n_state = ST_CWR;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_bit   = r_res_bit;
                    n_m_err   = r_res_err;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (f_fin) begin
            if (out_free) begin
                n_m_valid = 1'b1;
                n_m_bit   = f_bit;
                n_m_err   = f_err;
                n_state   = ST_IDLE;
            end else begin
                n_res_bit = f_bit;
                n_res_err = f_err;
                n_state   = ST_DONE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_vld     <= n_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_cnt     <= n_cnt;
        r_val     <= n_val;
        r_res_bit <= n_res_bit;
        r_res_err <= n_res_err;
        r_m_bit   <= n_m_bit;
        r_m_err   <= n_m_err;
    end

    assign s_axis_tready = idle;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-2){1'b0}}, r_m_err, r_m_bit};

endmodule

@@ rtl/bagsc_checker.sv @@
// ----------------------------------------------------------------------------
// bagsc_checker
// Port-level checks of the bit array get / set / copy block.
// ----------------------------------------------------------------------------
module bagsc_checker
    import bagsc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [OP_W-1:0]      s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // an error never comes with a read bit
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("read bit set together with range error");

    // unknown operation with a free output gives an empty result next cycle
    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
            && s_axis_tuser != OP_GET && s_axis_tuser != OP_SET
            && s_axis_tuser != OP_COPY
        |=> m_axis_tvalid && m_axis_tdata[1:0] == 2'b00)
        else $error("unknown operation not answered with empty result");

endmodule

bind bit_array_get_set_copy bagsc_checker u_bagsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
